// File: rtl/core/sha1_pkg.sv
// Shared types and constants for the SHA-1 byte stream hasher.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package sha1_pkg;

   localparam int unsigned ROUND_COUNT = 80;
   localparam int unsigned DIGEST_WORDS = 5;

   localparam logic [4:0][31:0] H_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_FIELD_POS = 6'd56;
   localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
   localparam logic [6:0] ROUND_LAST = 7'(ROUND_COUNT - 1);
   localparam logic [2:0] WORD_INDEX_LAST = 3'(DIGEST_WORDS - 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_ADD   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      BLK_HOLD  = 2'd0,
      BLK_MSG   = 2'd1,
      BLK_PAD   = 2'd2,
      BLK_ROUND = 2'd3
   } blk_op_type;

   typedef enum logic [1:0] {
      PAD_MARK = 2'd0,
      PAD_ZERO = 2'd1,
      PAD_LEN  = 2'd2
   } pad_kind_type;

   typedef struct packed {
      blk_op_type   blk_op;
      pad_kind_type pad_kind;
      logic         load_work;
      logic         round;
      logic         add_chain;
      logic         emit;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       rnd_last;
      logic       out_busy;
   } sts_type;

   function automatic logic [31:0] round_const(input logic [1:0] grp);
      logic [31:0] k;
      unique case (grp)
         2'd0: k = 32'h5a827999;
         2'd1: k = 32'h6ed9eba1;
         2'd2: k = 32'h8f1bbcdc;
         default: k = 32'hca62c1d6;
      endcase
      return k;
   endfunction

endpackage

// File: rtl/core/sha1_dpath.sv
// Datapath of the SHA-1 hasher: block shift register, message schedule,
// round logic, chaining words, byte and bit counters and the digest output register.
// Depends on sha1_pkg.
module sha1_dpath (
   input  logic              clock,
   input  logic              reset,
   input  sha1_pkg::req_type req_data,
   input  sha1_pkg::cmd_type cmd,
   output sha1_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sha1_pkg::rsp_type rsp_data
);

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   logic [511:0]      blk_ff, blk_in;
   logic [5:0]        fill_ff, fill_in;
   logic [60:0]       cnt_ff, cnt_in;
   logic [6:0]        rnd_ff, rnd_in;
   logic [4:0][31:0]  h_ff, h_in;
   logic [4:0][31:0]  v_ff, v_in;
   logic [4:0][31:0]  dig_ff, dig_in;
   logic [2:0]        idx_ff, idx_in;
   logic              oval_ff, oval_in;

   logic [63:0] bit_len;
   logic [7:0]  len_byte, pad_byte;
   logic [31:0] w0, w2, w8, w13, w_next;
   logic [1:0]  grp;
   logic [31:0] f, tmp;
   logic        rsp_take;

   assign w0  = blk_ff[511:480];
   assign w2  = blk_ff[447:416];
   assign w8  = blk_ff[255:224];
   assign w13 = blk_ff[95:64];
   // The window holds W[t]..W[t+15]; this is W[t+16].
   assign w_next = rotl(w13 ^ w8 ^ w2 ^ w0, 1);

   assign bit_len = {cnt_ff, 3'b000};

   always_comb begin
      unique case (fill_ff[2:0])
         3'd0: len_byte = bit_len[63:56];
         3'd1: len_byte = bit_len[55:48];
         3'd2: len_byte = bit_len[47:40];
         3'd3: len_byte = bit_len[39:32];
         3'd4: len_byte = bit_len[31:24];
         3'd5: len_byte = bit_len[23:16];
         3'd6: len_byte = bit_len[15:8];
         default: len_byte = bit_len[7:0];
      endcase
   end

   always_comb begin
      unique case (cmd.pad_kind)
         sha1_pkg::PAD_MARK: pad_byte = sha1_pkg::PAD_MARK_BYTE;
         sha1_pkg::PAD_LEN:  pad_byte = len_byte;
         default:            pad_byte = 8'h00;
      endcase
   end

   always_comb begin
      priority if (rnd_ff < 7'd20) grp = 2'd0;
      else if (rnd_ff < 7'd40)     grp = 2'd1;
      else if (rnd_ff < 7'd60)     grp = 2'd2;
      else                         grp = 2'd3;
   end

   always_comb begin
      unique case (grp)
         2'd0: f = (v_ff[1] & v_ff[2]) | (~v_ff[1] & v_ff[3]);
         2'd2: f = (v_ff[1] & v_ff[2]) | (v_ff[1] & v_ff[3]) | (v_ff[2] & v_ff[3]);
         default: f = v_ff[1] ^ v_ff[2] ^ v_ff[3];
      endcase
   end

   assign tmp = rotl(v_ff[0], 5) + f + v_ff[4] + sha1_pkg::round_const(grp) + w0;

   assign rsp_take = oval_ff && rsp_ready;

   always_comb begin
      blk_in  = blk_ff;
      fill_in = fill_ff;
      cnt_in  = cnt_ff;
      rnd_in  = rnd_ff;
      h_in    = h_ff;
      v_in    = v_ff;
      dig_in  = dig_ff;
      idx_in  = idx_ff;
      oval_in = oval_ff;

      unique case (cmd.blk_op)
         sha1_pkg::BLK_MSG: begin
            blk_in  = {blk_ff[503:0], req_data.data_byte};
            fill_in = fill_ff + 6'd1;
            cnt_in  = cnt_ff + 61'd1;
         end
         sha1_pkg::BLK_PAD: begin
            blk_in  = {blk_ff[503:0], pad_byte};
            fill_in = fill_ff + 6'd1;
         end
         sha1_pkg::BLK_ROUND: blk_in = {blk_ff[479:0], w_next};
         default: ;
      endcase

      if (cmd.load_work) begin
         v_in   = h_ff;
         rnd_in = 7'd0;
      end else if (cmd.round) begin
         v_in[4] = v_ff[3];
         v_in[3] = v_ff[2];
         v_in[2] = rotl(v_ff[1], 30);
         v_in[1] = v_ff[0];
         v_in[0] = tmp;
         rnd_in  = rnd_ff + 7'd1;
      end

      if (cmd.add_chain) begin
         for (int i = 0; i < 5; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end

      if (rsp_take) begin
         for (int i = 0; i < 4; i++) begin
            dig_in[i] = dig_ff[i + 1];
         end
         idx_in = idx_ff + 3'd1;
         if (idx_ff == sha1_pkg::WORD_INDEX_LAST) begin
            oval_in = 1'b0;
         end
      end

      // The controller only emits while the output register is empty.
      if (cmd.emit) begin
         dig_in  = h_ff;
         idx_in  = 3'd0;
         oval_in = 1'b1;
         h_in    = sha1_pkg::H_INIT;
         cnt_in  = 61'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 6'd0;
         cnt_ff  <= 61'd0;
         h_ff    <= sha1_pkg::H_INIT;
         oval_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else begin
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
         h_ff    <= h_in;
         oval_ff <= oval_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      rnd_ff <= rnd_in;
      v_ff   <= v_in;
      dig_ff <= dig_in;
   end

   assign sts.fill     = fill_ff;
   assign sts.rnd_last = (rnd_ff == sha1_pkg::ROUND_LAST);
   assign sts.out_busy = oval_ff;

   assign rsp_valid            = oval_ff;
   assign rsp_data.digest_word = dig_ff[0];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.last_word   = (idx_ff == sha1_pkg::WORD_INDEX_LAST);

endmodule

// File: rtl/core/sha1_ctrl.sv
// Controller of the SHA-1 hasher: sequences byte intake, padding,
// the 80 compression rounds, the chaining add and digest hand-off.
// Depends on sha1_pkg.
module sha1_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sha1_pkg::req_type req_data,
   input  sha1_pkg::sts_type sts,
   output sha1_pkg::cmd_type cmd
);

   sha1_pkg::state_type state_ff, state_in;
   logic fin_ff, fin_in;
   logic first_ff, first_in;
   logic len_ok_ff, len_ok_in;
   logic last_blk_ff, last_blk_in;
   logic block_full;

   assign block_full = (sts.fill == sha1_pkg::BLOCK_LAST_POS);
   assign req_ready  = (state_ff == sha1_pkg::ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      fin_in      = fin_ff;
      first_in    = first_ff;
      len_ok_in   = len_ok_ff;
      last_blk_in = last_blk_ff;

      cmd.blk_op    = sha1_pkg::BLK_HOLD;
      cmd.pad_kind  = sha1_pkg::PAD_ZERO;
      cmd.load_work = 1'b0;
      cmd.round     = 1'b0;
      cmd.add_chain = 1'b0;
      cmd.emit      = 1'b0;

      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.last) begin
                  fin_in    = 1'b1;
                  first_in  = 1'b1;
                  len_ok_in = 1'b0;
               end
               if (req_data.has_byte) begin
                  cmd.blk_op = sha1_pkg::BLK_MSG;
               end
               if (req_data.has_byte && block_full) begin
                  cmd.load_work = 1'b1;
                  last_blk_in   = 1'b0;
                  state_in      = sha1_pkg::ST_ROUND;
               end else if (req_data.last) begin
                  state_in = sha1_pkg::ST_PAD;
               end
            end
         end
         sha1_pkg::ST_PAD: begin
            cmd.blk_op = sha1_pkg::BLK_PAD;
            priority if (first_ff) begin
               cmd.pad_kind = sha1_pkg::PAD_MARK;
               first_in     = 1'b0;
               // The length fits behind the marker only if the marker lands before it.
               len_ok_in    = (sts.fill < sha1_pkg::LEN_FIELD_POS);
            end else if (len_ok_ff && sts.fill >= sha1_pkg::LEN_FIELD_POS) begin
               cmd.pad_kind = sha1_pkg::PAD_LEN;
            end else begin
               cmd.pad_kind = sha1_pkg::PAD_ZERO;
            end
            if (block_full) begin
               cmd.load_work = 1'b1;
               last_blk_in   = (cmd.pad_kind == sha1_pkg::PAD_LEN);
               state_in      = sha1_pkg::ST_ROUND;
            end
         end
         sha1_pkg::ST_ROUND: begin
            cmd.blk_op = sha1_pkg::BLK_ROUND;
            cmd.round  = 1'b1;
            if (sts.rnd_last) begin
               state_in = sha1_pkg::ST_ADD;
            end
         end
         sha1_pkg::ST_ADD: begin
            cmd.add_chain = 1'b1;
            priority if (last_blk_ff) begin
               state_in = sha1_pkg::ST_DONE;
            end else if (fin_ff) begin
               // A further block of padding follows; it carries the length, and
               // also the marker first if that has not been written yet.
               len_ok_in = !first_ff;
               state_in  = sha1_pkg::ST_PAD;
            end else begin
               state_in = sha1_pkg::ST_IDLE;
            end
         end
         sha1_pkg::ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.emit    = 1'b1;
               fin_in      = 1'b0;
               last_blk_in = 1'b0;
               state_in    = sha1_pkg::ST_IDLE;
            end
         end
         default: state_in = sha1_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sha1_pkg::ST_IDLE;
         fin_ff      <= 1'b0;
         first_ff    <= 1'b0;
         len_ok_ff   <= 1'b0;
         last_blk_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fin_ff      <= fin_in;
         first_ff    <= first_in;
         len_ok_ff   <= len_ok_in;
         last_blk_ff <= last_blk_in;
      end
   end

endmodule

// File: rtl/core/sha1_byte_stream_hasher_unit.sv
// Top level of the SHA-1 byte stream hasher: controller plus datapath.
// Depends on sha1_pkg, sha1_ctrl and sha1_dpath.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    sha1_pkg::req_type (byte, has_byte, last)
//   rsp       out        rsp_valid/rsp_ready    sha1_pkg::rsp_type (digest word, index, last)
//
// Bytes are taken while the unit is idle; every 64th byte starts a compression (80 rounds of the
// single shared round unit plus the chaining add), during which the input is not ready.
// A last item adds padding bytes up to the block end, one or two compressions and the
// hand-off into the output register; the five digest words then leave from it, one a
// cycle unless rsp_ready stalls them, while the next message is already taken in.
// Reset is synchronous; it restores the initial hash values and clears the fill and length counts and the output valid.
// A stalled result delays the hand-off of the following digest, and the input
// waits until that hand-off has happened.
module sha1_byte_stream_hasher_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sha1_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sha1_pkg::rsp_type rsp_data
);

   sha1_pkg::cmd_type cmd;
   sha1_pkg::sts_type sts;

   sha1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .sts       (sts),
      .cmd       (cmd)
   );

   sha1_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/core/sha1_checker.sv
// Port-level checker for the SHA-1 hasher, bound to the top level.
// Depends on sha1_pkg and sha1_byte_stream_hasher_unit.
module sha1_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input sha1_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sha1_pkg::rsp_type rsp_data
);

   // A stalled result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled digest word changed");

   // The digest words follow each other without gaps, in order.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word |=>
         rsp_valid && (rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest words out of sequence");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.word_index <= sha1_pkg::WORD_INDEX_LAST &&
         rsp_data.last_word == (rsp_data.word_index == sha1_pkg::WORD_INDEX_LAST))
      else $error("bad word index or last flag");

   // An empty item that does not end the message leaves the block ready.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_data.has_byte && !req_data.last |=> req_ready)
      else $error("empty item stalled the input");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sha1_byte_stream_hasher_unit sha1_checker u_sha1_checker (.*);
